// ===== rtl/pttr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pose to odometry package
// Shared widths, transaction types, the CORDIC arctangent table and the
// constants of the gain compensation.
// ----------------------------------------------------------------------------
package pttr_pkg;

	localparam int POS_W        = 24;
	localparam int ANG_W        = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int DIST_W       = POS_W + 1;
	localparam int DIFF_W       = POS_W + 1;
	localparam int GUARD_BITS   = 16;
	localparam int X_W          = DIFF_W + GUARD_BITS + 3;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);

	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam int          GAIN_W      = 30;
	localparam logic [29:0] GAIN_Q30    = 30'd652032874;
	localparam logic [31:0] SQRT2_Q30   = 32'd1518500250;
	localparam int          LEN_LO_BITS = 20;
	localparam int          UX_W        = X_W - 1;
	localparam int          MUL_A_W     = UX_W - LEN_LO_BITS;
	localparam int          MUL_W       = MUL_A_W + GAIN_W;
	localparam int          SUM_W       = MUL_W + 1;
	localparam int          LEN_SHIFT   = GUARD_BITS + 10;
	localparam int          D_W         = SUM_W - LEN_SHIFT;

	localparam logic [63:0] DIST_MAX64 =
		(((64'd1 << POS_W) - 64'd1) * 64'(SQRT2_Q30) + (64'd1 << 30) - 64'd1) >> 30;
	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(DIST_MAX64);

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [ANG_W-1:0] heading;
	} pose_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] first_turn;
		logic        [DIST_W-1:0] distance;
		logic signed [ANG_W-1:0] second_turn;
	} odo_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} vec_cmd_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ANG_W-1:0]  bearing;
		logic [DIST_W-1:0] length;
	} vec_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/pttr_vector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vectoring CORDIC unit
// Turns a displacement into bearing and gain-compensated length, one CORDIC
// step per cycle, then two passes through one shared multiplier.
// ----------------------------------------------------------------------------
module pttr_vector import pttr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vec_cmd_t cmd,
	output vec_rsp_t      rsp
);

	typedef enum logic [4:0] {
		V_IDLE = 5'b00001,
		V_ROT  = 5'b00010,
		V_MHI  = 5'b00100,
		V_MLO  = 5'b01000,
		V_FIN  = 5'b10000
	} vstate_t;

	vstate_t                   state_q;
	logic                      done_q;
	logic                      zero_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [X_W-1:0]     x_q;
	logic signed [X_W-1:0]     y_q;
	logic [31:0]               z_q;
	logic [MUL_W-1:0]          hi_q;
	logic [MUL_W-LEN_LO_BITS-1:0] lo_q;
	logic [ANG_W-1:0]          bearing_q;
	logic [DIST_W-1:0]         length_q;

	logic signed [X_W-1:0] dx_sh;
	logic signed [X_W-1:0] dy_sh;
	logic signed [X_W-1:0] xs;
	logic signed [X_W-1:0] ys;
	logic [31:0]           atan_v;
	logic [UX_W-1:0]       ux;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_W-1:0]      mul_p;
	logic [SUM_W-1:0]      p_sum;
	logic [SUM_W-1:0]      p_rnd;
	logic [D_W-1:0]        d_v;
	logic [31:0]           z_rnd;

	always_comb begin
		dx_sh  = {{(X_W-DIFF_W){cmd.dx[DIFF_W-1]}}, cmd.dx} <<< GUARD_BITS;
		dy_sh  = {{(X_W-DIFF_W){cmd.dy[DIFF_W-1]}}, cmd.dy} <<< GUARD_BITS;
		xs     = x_q >>> step_q;
		ys     = y_q >>> step_q;
		atan_v = ATAN_TURNS[ATAN_IDX_W'(step_q)];
		ux     = x_q[X_W-1] ? '0 : x_q[UX_W-1:0];
		mul_a  = (state_q == V_MHI) ? ux[UX_W-1:LEN_LO_BITS]
		                            : MUL_A_W'(ux[LEN_LO_BITS-1:0]);
		mul_p  = MUL_W'(mul_a) * MUL_W'(GAIN_Q30);
		p_sum  = SUM_W'(hi_q) + SUM_W'(lo_q);
		p_rnd  = p_sum + (SUM_W'(1) << (LEN_SHIFT - 1));
		d_v    = p_rnd[SUM_W-1:LEN_SHIFT];
		z_rnd  = z_q + (32'd1 << (31 - ANG_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == V_FIN);
			unique case (state_q)
				V_IDLE: begin
					if (cmd.start) begin
						state_q <= (cmd.dx == '0 && cmd.dy == '0) ? V_FIN : V_ROT;
					end
				end
				V_ROT: begin
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= V_MHI;
					end
				end
				V_MHI: state_q <= V_MLO;
				V_MLO: state_q <= V_FIN;
				V_FIN: state_q <= V_IDLE;
				default: state_q <= V_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			V_IDLE: begin
				step_q <= '0;
				zero_q <= (cmd.dx == '0 && cmd.dy == '0);
				if (cmd.dx[DIFF_W-1]) begin
					x_q <= -dx_sh;
					y_q <= -dy_sh;
					z_q <= 32'h8000_0000;
				end else begin
					x_q <= dx_sh;
					y_q <= dy_sh;
					z_q <= '0;
				end
			end
			V_ROT: begin
				step_q <= step_q + STEP_W'(1);
				if (!y_q[X_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end
			end
			V_MHI: hi_q <= mul_p;
			V_MLO: lo_q <= mul_p[MUL_W-1:LEN_LO_BITS];
			V_FIN: begin
				if (zero_q) begin
					bearing_q <= '0;
					length_q  <= '0;
				end else begin
					bearing_q <= z_rnd[31:32-ANG_W];
					length_q  <= (d_v > D_W'(DIST_MAX)) ? DIST_MAX : d_v[DIST_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign rsp.busy    = !state_q[0];
	assign rsp.done    = done_q;
	assign rsp.bearing = bearing_q;
	assign rsp.length  = length_q;

endmodule
`default_nettype wire

// ===== rtl/pose_to_odometry_rot_trans_rot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pose to rotation-translation-rotation odometry
// Keeps the previous pose and reports first turn, distance and second turn
// for every new pose.
// ----------------------------------------------------------------------------
// Each pose transaction yields exactly one odometry transaction. The first pose
// after reset yields all zeros and goes from acceptance straight to the emit
// state, which loads the output register. A pose that has not moved from the
// previous one skips the CORDIC steps. Every other pose runs sixteen vectoring
// CORDIC steps, one per cycle, then two passes through the shared gain
// multiplier and a final rounding step. pose_ready is low from acceptance until
// the result has moved from the emit state into the output register. A finished
// result waits in the emit state while the output register still holds a result
// that has not been taken. A finished result waits in the output register, so
// the next pose may be accepted before the previous result has been taken.
// ----------------------------------------------------------------------------
module pose_to_odometry_rot_trans_rot import pttr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pose_valid,
	output logic       pose_ready,
	input  wire pose_t pose,
	output logic       odo_valid,
	input  wire logic  odo_ready,
	output odo_t       odo
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WAIT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                  state_q;
	logic                    have_prev_q;
	logic                    odo_valid_q;
	logic signed [POS_W-1:0] last_x_q;
	logic signed [POS_W-1:0] last_y_q;
	logic [ANG_W-1:0]        hprev_q;
	logic [ANG_W-1:0]        hnew_q;
	odo_t                    res_q;
	odo_t                    odo_q;

	vec_cmd_t         vec_cmd;
	vec_rsp_t         vec_rsp;
	logic             accept;
	logic             out_free;
	logic [ANG_W-1:0] t1;
	logic [ANG_W-1:0] t2;

	assign accept   = pose_valid && pose_ready;
	assign out_free = !odo_valid_q || odo_ready;

	always_comb begin
		vec_cmd.start = accept && have_prev_q;
		vec_cmd.dx    = {pose.pos_x[POS_W-1], pose.pos_x} - {last_x_q[POS_W-1], last_x_q};
		vec_cmd.dy    = {pose.pos_y[POS_W-1], pose.pos_y} - {last_y_q[POS_W-1], last_y_q};
		t1            = vec_rsp.bearing - hprev_q;
		t2            = hnew_q - hprev_q - t1;
	end

	pttr_vector u_vector (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (vec_cmd),
		.rsp    (vec_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			odo_valid_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			hnew_q      <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				odo_valid_q <= 1'b1;
			end else if (odo_ready) begin
				odo_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						last_x_q    <= pose.pos_x;
						last_y_q    <= pose.pos_y;
						hnew_q      <= pose.heading;
						state_q     <= have_prev_q ? ST_WAIT : ST_EMIT;
					end
				end
				ST_WAIT: begin
					if (vec_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			hprev_q <= hnew_q;
			if (!have_prev_q) begin
				res_q <= '0;
			end
		end
		if (state_q == ST_WAIT && vec_rsp.done) begin
			res_q.first_turn  <= t1;
			res_q.distance    <= vec_rsp.length;
			res_q.second_turn <= t2;
		end
		if (state_q == ST_EMIT && out_free) begin
			odo_q <= res_q;
		end
	end

	assign pose_ready = (state_q == ST_IDLE);
	assign odo_valid  = odo_valid_q;
	assign odo        = odo_q;

	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pose_ready |-> !vec_rsp.busy)
		else $error("pose accepted while the CORDIC unit is still busy");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		vec_rsp.done |-> state_q == ST_WAIT)
		else $error("CORDIC result arrived with no pose waiting for it");

	a_first_pose_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !have_prev_q) |=> (state_q == ST_EMIT && !vec_rsp.busy))
		else $error("first pose after reset started the CORDIC unit");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vec_cmd.start |=> (vec_rsp.busy && state_q == ST_WAIT))
		else $error("CORDIC unit did not take up a started transaction");

endmodule
`default_nettype wire

// ===== verif/odometry_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry comparison
// Watches the pose and odometry channels, predicts the rotation-translation-
// rotation result of every accepted pose and compares it with the odometry
// transactions that leave the block, oldest expectation first.
// ----------------------------------------------------------------------------
module odometry_compare import pttr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pose_valid,
	input  wire logic  pose_ready,
	input  wire pose_t pose,
	input  wire logic  odo_valid,
	input  wire logic  odo_ready,
	input  wire odo_t  odo,
	output int         fail_count,
	output int         pending
);

	odo_t              expected_odo [$];
	odo_t              want;
	longint            prev_x       = 0;
	longint            prev_y       = 0;
	logic [ANG_W-1:0]  prev_heading = '0;
	bit                have_prev    = 1'b0;

	// Vectoring CORDIC on the displacement, with gain compensation and saturation.
	function automatic void polar_of(input longint dx, input longint dy,
			output logic [ANG_W-1:0] bearing, output logic [DIST_W-1:0] len);
		longint                 x;
		longint                 y;
		longint                 xs;
		longint                 ys;
		logic [31:0]            z;
		logic [32:0]            z_round;
		longint unsigned        ux;
		longint unsigned        prod;
		longint unsigned        d;
		x = dx * (64'sd1 <<< GUARD_BITS);
		y = dy * (64'sd1 <<< GUARD_BITS);
		z = '0;
		if (dx == 0 && dy == 0) begin
			bearing = '0;
			len = '0;
			return;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURNS[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURNS[i];
			end
		end
		z_round = {1'b0, z} + (33'd1 << (31 - ANG_W));
		bearing = z_round[31 -: ANG_W];
		ux = (x > 0) ? longint'(x) : 64'd0;
		prod = (ux >> 20) * 64'(GAIN_Q30) + (((ux & 64'hF_FFFF) * 64'(GAIN_Q30)) >> 20);
		d = (prod + (64'd1 << (GUARD_BITS + 9))) >> (GUARD_BITS + 10);
		len = (d > DIST_MAX64) ? DIST_MAX : DIST_W'(d);
	endfunction

	function automatic odo_t odometry_of(input pose_t p);
		odo_t             r;
		logic [ANG_W-1:0] bearing;
		logic [DIST_W-1:0] len;
		logic [ANG_W-1:0] t1;
		r = '0;
		if (have_prev) begin
			polar_of(longint'(p.pos_x) - prev_x, longint'(p.pos_y) - prev_y, bearing, len);
			t1 = bearing - prev_heading;
			r.first_turn = t1;
			r.distance = len;
			r.second_turn = p.heading - prev_heading - t1;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_odo.delete();
			prev_x = 0;
			prev_y = 0;
			prev_heading = '0;
			have_prev = 1'b0;
			pending <= 0;
		end else begin
			if (odo_valid && odo_ready) begin
				if (expected_odo.size() == 0) begin
					$display("%0t: odometry transaction with none expected, actual %0d %0d %0d",
						$time, odo.first_turn, odo.distance, odo.second_turn);
					fail_count++;
				end else begin
					want = expected_odo.pop_front();
					check_field("first_turn", longint'(want.first_turn),
						longint'(odo.first_turn));
					check_field("distance", longint'(want.distance), longint'(odo.distance));
					check_field("second_turn", longint'(want.second_turn),
						longint'(odo.second_turn));
				end
			end
			if (pose_valid && pose_ready) begin
				expected_odo.insert(expected_odo.size(), odometry_of(pose));
				prev_x = longint'(pose.pos_x);
				prev_y = longint'(pose.pos_y);
				prev_heading = pose.heading;
				have_prev = 1'b1;
			end
			pending <= expected_odo.size();
		end
	end

endmodule

// ===== verif/pose_to_odometry_rot_trans_rot_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose to odometry testbench
// Drives directed and random pose transactions with random idling on both
// channels, lets the comparison module check every odometry transaction and
// gives the verdict.
// ----------------------------------------------------------------------------
module pose_to_odometry_rot_trans_rot_tb;
	import pttr_pkg::*;

	localparam int P_MAX = (1 << (POS_W - 1)) - 1;
	localparam int P_MIN = -(1 << (POS_W - 1));
	localparam int H_MAX = (1 << (ANG_W - 1)) - 1;
	localparam int H_MIN = -(1 << (ANG_W - 1));
	localparam int RANDOM_POSES = 700;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  pose_valid = 1'b0;
	logic  pose_ready;
	pose_t pose       = '0;
	logic  odo_valid;
	logic  odo_ready  = 1'b0;
	odo_t  odo;
	int    fail_count;
	int    pending;
	bit    pose_idle  = 1'b0;
	bit    odo_idle   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL pose_to_odometry_rot_trans_rot");
		$finish;
	end

	pose_to_odometry_rot_trans_rot dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.pose       (pose),
		.odo_valid  (odo_valid),
		.odo_ready  (odo_ready),
		.odo        (odo)
	);

	odometry_compare u_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.pose       (pose),
		.odo_valid  (odo_valid),
		.odo_ready  (odo_ready),
		.odo        (odo),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic pose_t make_pose(input int x, input int y, input int h);
		pose_t p;
		p.pos_x = x[POS_W-1:0];
		p.pos_y = y[POS_W-1:0];
		p.heading = h[ANG_W-1:0];
		return p;
	endfunction

	// Valid is left high after a transaction, so a back-to-back pose needs no lowering.
	task automatic send_pose(input pose_t p);
		int gap;
		gap = pose_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			pose_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_valid <= 1'b1;
		pose <= p;
		do @(posedge clk); while (!pose_ready);
	endtask

	task automatic drain_results();
		pose_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : odo_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = odo_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				odo_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			odo_ready <= 1'b1;
			do @(posedge clk); while (!odo_valid);
		end
	end

	initial begin : stimulus
		pose_t                  plan [$];
		pose_t                  p;
		pose_t                  last_sent;
		int                     kind;
		int                     k;
		logic signed [31:0]     step_x;
		logic signed [31:0]     step_y;
		logic signed [31:0]     step_h;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			make_pose(0, 0, 0),
			make_pose(0, 0, H_MAX),
			make_pose(P_MAX, P_MAX, H_MIN),
			make_pose(P_MIN, P_MIN, H_MAX),
			make_pose(P_MAX, P_MIN, 0),
			make_pose(P_MIN, P_MAX, -1),
			make_pose(P_MIN, P_MAX, 1),
			make_pose(P_MAX, P_MAX, H_MIN),
			make_pose(P_MIN, P_MAX, 16384),
			make_pose(P_MIN, P_MIN, -16384),
			make_pose(P_MIN, P_MAX, 0),
			make_pose(P_MIN + 1, P_MAX, 0),
			make_pose(P_MIN + 1, P_MAX - 1, H_MAX),
			make_pose(P_MIN, P_MAX - 1, H_MIN),
			make_pose(0, 0, 0),
			make_pose(1, 1, 1),
			make_pose(0, 2, -1),
			make_pose(-1, 2, 8192),
			make_pose(-1, -1, -8192),
			make_pose(-1, -1, -8192),
			make_pose(P_MAX, 0, H_MAX),
			make_pose(P_MIN, 0, H_MIN),
			make_pose(0, P_MIN, 0),
			make_pose(0, P_MAX, 0)
		};
		foreach (plan[i])
			send_pose(plan[i]);
		last_sent = plan[plan.size() - 1];

		for (int n = 0; n < RANDOM_POSES; n++) begin
			if (n % (RANDOM_POSES / 4) == 0) begin
				pose_idle = ((n / (RANDOM_POSES / 4)) & 1) != 0;
				odo_idle = ((n / (RANDOM_POSES / 4)) & 2) != 0;
			end
			if (n == RANDOM_POSES / 2 + 7)
				drain_results();
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				p = pose_t'({$urandom, $urandom});
			end else if (kind == 1) begin
				p = last_sent;
				p.heading = ANG_W'($urandom);
			end else if (kind == 2) begin
				p = make_pose($urandom_range(0, 1) ? P_MAX : P_MIN,
					$urandom_range(0, 1) ? P_MAX : P_MIN, $urandom);
			end else begin
				k = $urandom_range(0, 23);
				step_x = $signed($urandom) >>> (31 - k);
				step_y = $signed($urandom) >>> (31 - k);
				step_h = $signed($urandom) >>> $urandom_range(16, 31);
				p.pos_x = last_sent.pos_x + step_x[POS_W-1:0];
				p.pos_y = last_sent.pos_y + step_y[POS_W-1:0];
				p.heading = last_sent.heading + step_h[ANG_W-1:0];
			end
			send_pose(p);
			last_sent = p;
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS pose_to_odometry_rot_trans_rot");
		end else begin
			$display("FAIL pose_to_odometry_rot_trans_rot");
		end
		$finish;
	end

endmodule
